@@ rtl/ground_plane_undistort_map_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ground-plane remap block
// Concurrent checks used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef GROUND_PLANE_UNDISTORT_MAP_MACROS_SVH
`define GROUND_PLANE_UNDISTORT_MAP_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define GPUM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpum: assertion failed");

// Next-cycle implication, masked while reset is asserted
`define GPUM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpum: assertion failed");

// Next-cycle implication that also holds through reset
`define GPUM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gpum: assertion failed");

`endif

@@ rtl/gpum_pkg.sv @@
// ----------------------------------------------------------------------------
// gpum_pkg
// Types, widths, register indexes and arithmetic helpers of the remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpum_pkg;

  localparam int COORD_BITS    = 12;
  localparam int OUT_FRAC_BITS = 8;

  localparam int IN_W      = 12;
  localparam int OUT_W     = 32;
  localparam int FLD_W     = 21;
  localparam int REG_W     = 63;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_REGS  = 8;
  localparam int NFRAC     = 20;

  // Datapath widths
  localparam int PW  = 22;          // plane coordinate, Q.4
  localparam int HW  = 45;          // homography sums, Q.23
  localparam int RW  = HW + 2;      // divider remainder
  localparam int INT_BITS = 3;      // integer quotient bits
  localparam int QW  = INT_BITS + NFRAC;
  localparam int NW  = QW + 1;      // normalised coordinate, signed Q3.20
  localparam int AW  = 30;          // tangential helper terms
  localparam int DW  = 43;          // distorted coordinate, signed Q.20
  localparam int XW  = 72;          // scratch width for rounding and clamping

  localparam logic [2:0] REG_X_ROW      = 3'd0;
  localparam logic [2:0] REG_Y_ROW      = 3'd1;
  localparam logic [2:0] REG_Z_ROW      = 3'd2;
  localparam logic [2:0] REG_FOCAL      = 3'd3;
  localparam logic [2:0] REG_PRINCIPAL  = 3'd4;
  localparam logic [2:0] REG_RADIAL     = 3'd5;
  localparam logic [2:0] REG_TANGENTIAL = 3'd6;
  localparam logic [2:0] REG_PLANE_OFS  = 3'd7;

  typedef logic [REG_W-1:0] gpum_word_t;

  typedef struct packed {
    logic [IN_W-1:0] grid_column;
    logic [IN_W-1:0] grid_row;
  } gpum_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] source_x;
    logic signed [OUT_W-1:0] source_y;
    logic                    invalid;
  } gpum_out_t;

  typedef struct packed {
    gpum_word_t x_row;
    gpum_word_t y_row;
    gpum_word_t z_row;
    gpum_word_t focal;
    gpum_word_t principal;
    gpum_word_t radial;
    gpum_word_t tangential;
    gpum_word_t plane;
  } gpum_cfg_t;

  function automatic logic signed [FLD_W-1:0] fld_s(input gpum_word_t w, input int idx);
    return $signed(w[idx*FLD_W +: FLD_W]);
  endfunction

  function automatic logic [FLD_W-1:0] fld_u(input gpum_word_t w, input int idx);
    return w[idx*FLD_W +: FLD_W];
  endfunction

  // Round half up and drop s fraction bits
  function automatic logic signed [XW-1:0] rnd_sh(input logic signed [XW-1:0] v, input int s);
    logic signed [XW-1:0] half;
    half = {{(XW-1){1'b0}}, 1'b1} <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [XW-1:0] sat_clamp(input logic signed [XW-1:0] v,
                                                      input logic signed [XW-1:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic sat_over(input logic signed [XW-1:0] v,
                                    input logic signed [XW-1:0] lim);
    return (v > lim) || (v < -lim);
  endfunction

endpackage

`default_nettype wire

@@ rtl/gpum_homog.sv @@
// ----------------------------------------------------------------------------
// gpum_homog
// Plane offset and plane-to-camera homography, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gpum_homog (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  gpum_pkg::gpum_in_t                in_data,
  input  gpum_pkg::gpum_cfg_t               cfg,
  output logic                              v_o,
  output logic signed [gpum_pkg::HW-1:0]    hx_o,
  output logic signed [gpum_pkg::HW-1:0]    hy_o,
  output logic signed [gpum_pkg::HW-1:0]    hz_o
);
  import gpum_pkg::*;

  localparam int MW = FLD_W + PW;

  logic [COORD_BITS-1:0]   col, row;
  logic signed [PW-1:0]    pj_nxt, pi_nxt, pj_r, pi_r;
  logic signed [MW-1:0]    m_nxt [6];
  logic signed [MW-1:0]    m_r   [6];
  logic signed [HW-1:0]    hx_nxt, hy_nxt, hz_nxt, hx_r, hy_r, hz_r;
  logic                    v1_r, v2_r, v3_r;

  assign col = in_data.grid_column[COORD_BITS-1:0];
  assign row = in_data.grid_row[COORD_BITS-1:0];

  always_comb begin
    pj_nxt = $signed({{(PW-COORD_BITS-4){1'b0}}, col, 4'b0000}) + PW'(fld_s(cfg.plane, 0));
    pi_nxt = $signed({{(PW-COORD_BITS-4){1'b0}}, row, 4'b0000}) + PW'(fld_s(cfg.plane, 1));
    m_nxt[0] = fld_s(cfg.x_row, 0) * pj_r;
    m_nxt[1] = fld_s(cfg.x_row, 1) * pi_r;
    m_nxt[2] = fld_s(cfg.y_row, 0) * pj_r;
    m_nxt[3] = fld_s(cfg.y_row, 1) * pi_r;
    m_nxt[4] = fld_s(cfg.z_row, 0) * pj_r;
    m_nxt[5] = fld_s(cfg.z_row, 1) * pi_r;
    hx_nxt = HW'(m_r[0]) + HW'(m_r[1]) + (HW'(fld_s(cfg.x_row, 2)) <<< 19);
    hy_nxt = HW'(m_r[2]) + HW'(m_r[3]) + (HW'(fld_s(cfg.y_row, 2)) <<< 19);
    hz_nxt = HW'(m_r[4]) + HW'(m_r[5]) + (HW'(fld_s(cfg.z_row, 2)) <<< 19);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (adv) begin
      pj_r <= pj_nxt;
      pi_r <= pi_nxt;
      m_r  <= m_nxt;
      hx_r <= hx_nxt;
      hy_r <= hy_nxt;
      hz_r <= hz_nxt;
    end
  end

  assign v_o  = v3_r;
  assign hx_o = hx_r;
  assign hy_o = hy_r;
  assign hz_o = hz_r;

endmodule

`default_nettype wire

@@ rtl/gpum_div.sv @@
// ----------------------------------------------------------------------------
// gpum_div
// Pipelined restoring divider: x/z and y/z in signed Q3.20, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gpum_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            v_i,
  input  logic signed [gpum_pkg::HW-1:0]  hx_i,
  input  logic signed [gpum_pkg::HW-1:0]  hy_i,
  input  logic signed [gpum_pkg::HW-1:0]  hz_i,
  output logic                            v_o,
  output logic signed [gpum_pkg::NW-1:0]  xn_o,
  output logic signed [gpum_pkg::NW-1:0]  yn_o,
  output logic                            sat_o
);
  import gpum_pkg::*;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
    logic          nz;
  } lane_t;

  localparam logic [QW-1:0] NORM_MAX = '1;

  lane_t            lx_r [QW+1];
  lane_t            ly_r [QW+1];
  logic [HW-1:0]    d_r  [QW+1];
  logic             v_r  [QW+1];

  logic [HW-1:0]    nx, ny, dz;
  logic [QW-1:0]    magx, magy;
  logic signed [NW-1:0] xn_r, yn_r;
  logic             sat_r, vo_r;

  always_comb begin
    nx = hx_i[HW-1] ? HW'(-hx_i) : HW'(hx_i);
    ny = hy_i[HW-1] ? HW'(-hy_i) : HW'(hy_i);
    dz = hz_i[HW-1] ? HW'(-hz_i) : HW'(hz_i);
  end

  // Entry stage: magnitudes, signs and the overflow test against 8|z|
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (adv) v_r[0] <= v_i;
    if (adv) begin
      d_r[0]     <= dz;
      lx_r[0].r  <= RW'(nx);
      lx_r[0].q  <= '0;
      lx_r[0].neg <= hx_i[HW-1] ^ hz_i[HW-1];
      lx_r[0].ovf <= {3'b000, nx} >= {dz, 3'b000};
      lx_r[0].nz <= nx != '0;
      ly_r[0].r  <= RW'(ny);
      ly_r[0].q  <= '0;
      ly_r[0].neg <= hy_i[HW-1] ^ hz_i[HW-1];
      ly_r[0].ovf <= {3'b000, ny} >= {dz, 3'b000};
      ly_r[0].nz <= ny != '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] dsh, rsx, rsy;
    logic          gex, gey;

    if (k < INT_BITS) begin : g_int
      assign dsh = RW'(d_r[k]) << (INT_BITS - 1 - k);
      assign rsx = lx_r[k].r;
      assign rsy = ly_r[k].r;
    end else begin : g_frac
      assign dsh = RW'(d_r[k]);
      assign rsx = lx_r[k].r << 1;
      assign rsy = ly_r[k].r << 1;
    end

    assign gex = rsx >= dsh;
    assign gey = rsy >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else if (adv) v_r[k+1] <= v_r[k];
      if (adv) begin
        d_r[k+1]      <= d_r[k];
        lx_r[k+1].r   <= gex ? rsx - dsh : rsx;
        lx_r[k+1].q   <= {lx_r[k].q[QW-2:0], gex};
        lx_r[k+1].neg <= lx_r[k].neg;
        lx_r[k+1].ovf <= lx_r[k].ovf;
        lx_r[k+1].nz  <= lx_r[k].nz;
        ly_r[k+1].r   <= gey ? rsy - dsh : rsy;
        ly_r[k+1].q   <= {ly_r[k].q[QW-2:0], gey};
        ly_r[k+1].neg <= ly_r[k].neg;
        ly_r[k+1].ovf <= ly_r[k].ovf;
        ly_r[k+1].nz  <= ly_r[k].nz;
      end
    end
  end

  // Saturate on overflow or zero z, then apply the sign
  always_comb begin
    magx = lx_r[QW].ovf ? (lx_r[QW].nz ? NORM_MAX : '0) : lx_r[QW].q;
    magy = ly_r[QW].ovf ? (ly_r[QW].nz ? NORM_MAX : '0) : ly_r[QW].q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (adv) vo_r <= v_r[QW];
    if (adv) begin
      xn_r  <= lx_r[QW].neg ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
      yn_r  <= ly_r[QW].neg ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
      sat_r <= lx_r[QW].ovf | ly_r[QW].ovf;
    end
  end

  assign v_o   = vo_r;
  assign xn_o  = xn_r;
  assign yn_o  = yn_r;
  assign sat_o = sat_r;

endmodule

`default_nettype wire

@@ rtl/gpum_distort.sv @@
// ----------------------------------------------------------------------------
// gpum_distort
// Brown radial and tangential distortion, ten register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gpum_distort (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            v_i,
  input  logic signed [gpum_pkg::NW-1:0]  xn_i,
  input  logic signed [gpum_pkg::NW-1:0]  yn_i,
  input  logic                            sat_i,
  input  gpum_pkg::gpum_cfg_t             cfg,
  output logic                            v_o,
  output logic signed [gpum_pkg::DW-1:0]  xd_o,
  output logic signed [gpum_pkg::DW-1:0]  yd_o,
  output logic                            sat_o
);
  import gpum_pkg::*;

  localparam int SQW = 2 * NW;
  localparam int R2W = 29;
  localparam int R4W = 36;
  localparam int R6W = 43;
  localparam int K1W = 34;
  localparam int K2W = 41;
  localparam int CW  = 41;
  localparam logic signed [XW-1:0] ONE_Q20   = XW'(1) <<< NFRAC;
  localparam logic signed [XW-1:0] CDIST_MAX = (XW'(1) <<< 39) - 1;
  localparam logic signed [XW-1:0] DIST_MAX  = (XW'(1) <<< 41) - 1;

  typedef struct packed {
    logic signed [NW-1:0] xn;
    logic signed [NW-1:0] yn;
    logic signed [AW-1:0] a1;
    logic signed [AW-1:0] a2;
    logic signed [AW-1:0] a3;
    logic                 sat;
  } carry_t;

  carry_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r, c8_r;
  logic [9:0] v_r;

  logic signed [SQW-1:0]        pxx_r, pyy_r, pxy_r;
  logic signed [R2W-1:0]        xx, yy, xy, r2_nxt, r2_r, r2b_r, r2c_r;
  logic signed [2*R2W-1:0]      pr4_r;
  logic signed [FLD_W+R2W-1:0]  pk1_r;
  logic signed [R4W-1:0]        r4_r;
  logic signed [K1W-1:0]        k1t_r, k1t2_r, k1t3_r, k1t4_r;
  logic signed [R2W+R4W-1:0]    pr6_r;
  logic signed [FLD_W+R4W-1:0]  pk2_r;
  logic signed [R6W-1:0]        r6_r;
  logic signed [K2W-1:0]        k2t_r, k2t2_r;
  logic signed [FLD_W+R6W-1:0]  pk3_r;
  logic signed [XW-1:0]         cd_sum;
  logic signed [CW-1:0]         cd_r;
  logic signed [NW+CW-1:0]      pxd_r, pyd_r;
  logic signed [FLD_W+AW-1:0]   pp1a1_r, pp2a2_r, pp1a3_r, pp2a1_r;
  logic                         sat9_r;
  logic signed [XW-1:0]         xd_sum, yd_sum;
  logic signed [DW-1:0]         xd_r, yd_r;
  logic                         sat10_r;

  always_comb begin
    xx = R2W'(rnd_sh(XW'(pxx_r), NFRAC));
    yy = R2W'(rnd_sh(XW'(pyy_r), NFRAC));
    xy = R2W'(rnd_sh(XW'(pxy_r), NFRAC));
    r2_nxt = xx + yy;
    cd_sum = ONE_Q20 + XW'(k1t4_r) + XW'(k2t2_r) + rnd_sh(XW'(pk3_r), 17);
    xd_sum = rnd_sh(XW'(pxd_r), NFRAC) + rnd_sh(XW'(pp1a1_r), 17)
           + rnd_sh(XW'(pp2a2_r), 17);
    yd_sum = rnd_sh(XW'(pyd_r), NFRAC) + rnd_sh(XW'(pp1a3_r), 17)
           + rnd_sh(XW'(pp2a1_r), 17);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[8:0], v_i};
    if (adv) begin
      // squares and cross product
      pxx_r <= xn_i * xn_i;
      pyy_r <= yn_i * yn_i;
      pxy_r <= xn_i * yn_i;
      c1_r  <= '{xn: xn_i, yn: yn_i, a1: '0, a2: '0, a3: '0, sat: sat_i};
      // r2 and the tangential helpers
      r2_r  <= r2_nxt;
      c2_r  <= '{xn: c1_r.xn, yn: c1_r.yn, a1: AW'(xy) <<< 1,
                 a2: AW'(r2_nxt) + (AW'(xx) <<< 1), a3: AW'(r2_nxt) + (AW'(yy) <<< 1),
                 sat: c1_r.sat};
      // r4 product and k1 term
      pr4_r <= r2_r * r2_r;
      pk1_r <= fld_s(cfg.radial, 0) * r2_r;
      r2b_r <= r2_r;
      c3_r  <= c2_r;
      r4_r  <= R4W'(rnd_sh(XW'(pr4_r), NFRAC));
      k1t_r <= K1W'(rnd_sh(XW'(pk1_r), 17));
      r2c_r <= r2b_r;
      c4_r  <= c3_r;
      // r6 product and k2 term
      pr6_r  <= r2c_r * r4_r;
      pk2_r  <= fld_s(cfg.radial, 1) * r4_r;
      k1t2_r <= k1t_r;
      c5_r   <= c4_r;
      r6_r   <= R6W'(rnd_sh(XW'(pr6_r), NFRAC));
      k2t_r  <= K2W'(rnd_sh(XW'(pk2_r), 17));
      k1t3_r <= k1t2_r;
      c6_r   <= c5_r;
      // k3 term
      pk3_r  <= fld_s(cfg.radial, 2) * r6_r;
      k2t2_r <= k2t_r;
      k1t4_r <= k1t3_r;
      c7_r   <= c6_r;
      // distortion factor, clamped
      cd_r   <= CW'(sat_clamp(cd_sum, CDIST_MAX));
      c8_r   <= '{xn: c7_r.xn, yn: c7_r.yn, a1: c7_r.a1, a2: c7_r.a2, a3: c7_r.a3,
                  sat: c7_r.sat | sat_over(cd_sum, CDIST_MAX)};
      // radial and tangential products
      pxd_r   <= c8_r.xn * cd_r;
      pyd_r   <= c8_r.yn * cd_r;
      pp1a1_r <= fld_s(cfg.tangential, 0) * c8_r.a1;
      pp2a2_r <= fld_s(cfg.tangential, 1) * c8_r.a2;
      pp1a3_r <= fld_s(cfg.tangential, 0) * c8_r.a3;
      pp2a1_r <= fld_s(cfg.tangential, 1) * c8_r.a1;
      sat9_r  <= c8_r.sat;
      // distorted coordinates, clamped
      xd_r    <= DW'(sat_clamp(xd_sum, DIST_MAX));
      yd_r    <= DW'(sat_clamp(yd_sum, DIST_MAX));
      sat10_r <= sat9_r | sat_over(xd_sum, DIST_MAX) | sat_over(yd_sum, DIST_MAX);
    end
  end

  assign v_o   = v_r[9];
  assign xd_o  = xd_r;
  assign yd_o  = yd_r;
  assign sat_o = sat10_r;

endmodule

`default_nettype wire

@@ rtl/gpum_project.sv @@
// ----------------------------------------------------------------------------
// gpum_project
// Focal scaling, principal point and output saturation; holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gpum_project (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic                            v_i,
  input  logic signed [gpum_pkg::DW-1:0]  xd_i,
  input  logic signed [gpum_pkg::DW-1:0]  yd_i,
  input  logic                            sat_i,
  input  gpum_pkg::gpum_cfg_t             cfg,
  output logic                            out_valid,
  output gpum_pkg::gpum_out_t             out_data
);
  import gpum_pkg::*;

  localparam int LW  = 22;                 // low slice of the distorted value
  localparam int HIW = DW - LW;
  localparam int SW  = 67;
  localparam int FSH = 28 - OUT_FRAC_BITS;
  localparam logic signed [XW-1:0] OUT_MAX = XW'(32'sh7fff_ffff);
  localparam logic signed [XW-1:0] OUT_MIN = -OUT_MAX - XW'(1);

  logic [LW+FLD_W-1:0]             plx_r, ply_r;
  logic signed [HIW+FLD_W:0]       phx_r, phy_r;
  logic signed [SW-1:0]            sx_r, sy_r;
  logic signed [XW-1:0]            tx, ty;
  logic                            sat1_r, sat2_r, v1_r, v2_r, vo_r;
  gpum_out_t                       od_r;

  always_comb begin
    tx = rnd_sh(XW'(sx_r), FSH);
    ty = rnd_sh(XW'(sy_r), FSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      vo_r <= v2_r;
    end
    if (adv) begin
      // split products: unsigned low slice and signed high slice
      plx_r  <= xd_i[LW-1:0] * fld_u(cfg.focal, 0);
      ply_r  <= yd_i[LW-1:0] * fld_u(cfg.focal, 1);
      phx_r  <= $signed(xd_i[DW-1:LW]) * $signed({1'b0, fld_u(cfg.focal, 0)});
      phy_r  <= $signed(yd_i[DW-1:LW]) * $signed({1'b0, fld_u(cfg.focal, 1)});
      sat1_r <= sat_i;
      // recombine and add the principal point
      sx_r <= (SW'(phx_r) <<< LW) + SW'($signed({1'b0, plx_r}))
            + (SW'($signed({1'b0, fld_u(cfg.principal, 0)})) <<< NFRAC);
      sy_r <= (SW'(phy_r) <<< LW) + SW'($signed({1'b0, ply_r}))
            + (SW'($signed({1'b0, fld_u(cfg.principal, 1)})) <<< NFRAC);
      sat2_r <= sat1_r;
      // round and saturate to the output range
      od_r.source_x <= (tx > OUT_MAX) ? OUT_W'(OUT_MAX) :
                       (tx < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(tx);
      od_r.source_y <= (ty > OUT_MAX) ? OUT_W'(OUT_MAX) :
                       (ty < OUT_MIN) ? OUT_W'(OUT_MIN) : OUT_W'(ty);
      od_r.invalid  <= sat2_r | (tx > OUT_MAX) | (tx < OUT_MIN)
                     | (ty > OUT_MAX) | (ty < OUT_MIN);
    end
  end

  assign out_valid = vo_r;
  assign out_data  = od_r;

endmodule

`default_nettype wire

@@ rtl/ground_plane_undistort_map.sv @@
// ----------------------------------------------------------------------------
// ground_plane_undistort_map
// Remap coordinate generator: ground-plane grid position to distorted source
// image coordinates through homography, Brown distortion and camera intrinsics.
// ----------------------------------------------------------------------------
// One grid position is taken every clock and one result leaves every clock
// unless the sink stalls; the bit-per-stage divider forms x/z and y/z. The
// whole pipeline advances together: it freezes only while a result sits at the
// output and the sink stalls, so in_stall follows out_stall in that case alone.
// Coefficient registers are written through the cfg port (always ready); the
// user must write them only while the block is idle, as the block itself does
// not enforce it. A write to an index past the last register is dropped. Zero
// z, a normalised coordinate of eight or more, or any clamp on the distortion
// factor, the distorted point or the 32-bit output raises the invalid flag.
`default_nettype none

module ground_plane_undistort_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gpum_pkg::gpum_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gpum_pkg::gpum_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpum_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpum_pkg::REG_W-1:0]          cfg_data
);
  import gpum_pkg::*;

`include "ground_plane_undistort_map_macros.svh"

  gpum_word_t           cfg_r [NUM_REGS];
  gpum_cfg_t            cfg;
  logic                 adv;

  logic                 hv, dv, sv;
  logic signed [HW-1:0] hx, hy, hz;
  logic signed [NW-1:0] xn, yn;
  logic                 dsat, ssat;
  logic signed [DW-1:0] xd, yd;

  // Freeze every stage while the output transaction waits
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Coefficient registers; drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign cfg = '{x_row:      cfg_r[REG_X_ROW],
                 y_row:      cfg_r[REG_Y_ROW],
                 z_row:      cfg_r[REG_Z_ROW],
                 focal:      cfg_r[REG_FOCAL],
                 principal:  cfg_r[REG_PRINCIPAL],
                 radial:     cfg_r[REG_RADIAL],
                 tangential: cfg_r[REG_TANGENTIAL],
                 plane:      cfg_r[REG_PLANE_OFS]};

  gpum_homog u_homog (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(in_valid), .in_data(in_data), .cfg(cfg),
    .v_o(hv), .hx_o(hx), .hy_o(hy), .hz_o(hz)
  );

  gpum_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .v_i(hv), .hx_i(hx), .hy_i(hy), .hz_i(hz),
    .v_o(dv), .xn_o(xn), .yn_o(yn), .sat_o(dsat)
  );

  gpum_distort u_distort (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .v_i(dv), .xn_i(xn), .yn_i(yn), .sat_i(dsat), .cfg(cfg),
    .v_o(sv), .xd_o(xd), .yd_o(yd), .sat_o(ssat)
  );

  gpum_project u_project (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .v_i(sv), .xd_i(xd), .yd_i(yd), .sat_i(ssat), .cfg(cfg),
    .out_valid(out_valid), .out_data(out_data)
  );

  // Reset empties the pipeline
  `GPUM_ASSERT_NEXT_ALWAYS(a_reset_flush, clk, !rst_n, !out_valid)
  // A write past the register list leaves the x-row and plane-offset registers untouched
  `GPUM_ASSERT_NEXT(a_cfg_drop, clk, rst_n, cfg_valid && (cfg_index >= CFG_IDX_W'(NUM_REGS)), $stable(cfg_r[REG_X_ROW]) && $stable(cfg_r[REG_PLANE_OFS]))
  // A write to the radial register lands there
  `GPUM_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == CFG_IDX_W'(REG_RADIAL)), cfg_r[REG_RADIAL] == $past(cfg_data))
  // An empty output never holds off the source
  `GPUM_ASSERT_IMP(a_no_false_stall, clk, rst_n, !out_valid, !in_stall)

endmodule

`default_nettype wire

@@ bench/gpum_checker.sv @@
// ----------------------------------------------------------------------------
// gpum_checker
// Watches the grid, result and coefficient channels of the remap block,
// predicts each source coordinate in fixed point and compares it in order.
// ----------------------------------------------------------------------------
module gpum_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  gpum_pkg::gpum_in_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  gpum_pkg::gpum_out_t            out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gpum_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpum_pkg::REG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gpum_pkg::*;

  localparam longint NORM_LIM  = (64'sd1 <<< 23) - 1;
  localparam longint CDIST_LIM = (64'sd1 <<< 39) - 1;
  localparam longint DIST_LIM  = (64'sd1 <<< 41) - 1;

  gpum_word_t coeff [NUM_REGS];
  gpum_out_t  expected_coords [$];

  function automatic longint sfield(gpum_word_t w, int idx);
    longint v;
    v = longint'((w >> (FLD_W * idx)) & 63'h1FFFFF);
    return (v ^ 64'sh100000) - 64'sh100000;
  endfunction

  function automatic longint ufield(gpum_word_t w, int idx);
    return longint'((w >> (FLD_W * idx)) & 63'h1FFFFF);
  endfunction

  // round half up, then drop s fraction bits (arithmetic shift floors)
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim, inout bit sat);
    if (v > lim) begin
      sat = 1'b1;
      return lim;
    end
    if (v < -lim) begin
      sat = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  // num/den as signed Q3.20, truncated toward zero
  function automatic longint norm_quotient(longint num, longint den, inout bit sat);
    longint unsigned n, d, q, r;
    bit neg;
    n = num < 0 ? longint'(-num) : longint'(num);
    if (den == 0) begin
      sat = 1'b1;
      return num > 0 ? NORM_LIM : (num < 0 ? -NORM_LIM : 0);
    end
    d = den < 0 ? longint'(-den) : longint'(den);
    neg = (num < 0) != (den < 0);
    if (n >= (d << 3)) begin
      sat = 1'b1;
      q = NORM_LIM;
    end else begin
      q = n / d;
      r = n - q * d;
      for (int i = 0; i < NFRAC; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] project_axis(longint d, longint f, longint c,
                                                       inout bit sat);
    longint v;
    v = round_shift(d * f + c * (64'sd1 <<< NFRAC), 28 - OUT_FRAC_BITS);
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      sat = 1'b1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      sat = 1'b1;
    end
    return v[31:0];
  endfunction

  function automatic gpum_out_t predict_source(gpum_in_t g);
    gpum_out_t res;
    bit sat;
    longint pj, pi, hx, hy, hz, xn, yn, xx, yy, xy, r2, r4, r6, a1, a2, a3;
    longint cdist, xd, yd, k1, k2, k3, p1, p2;
    sat = 1'b0;
    k1 = sfield(coeff[REG_RADIAL], 0);
    k2 = sfield(coeff[REG_RADIAL], 1);
    k3 = sfield(coeff[REG_RADIAL], 2);
    p1 = sfield(coeff[REG_TANGENTIAL], 0);
    p2 = sfield(coeff[REG_TANGENTIAL], 1);
    pj = longint'(g.grid_column[COORD_BITS-1:0]) * 16 + sfield(coeff[REG_PLANE_OFS], 0);
    pi = longint'(g.grid_row[COORD_BITS-1:0]) * 16 + sfield(coeff[REG_PLANE_OFS], 1);
    hx = sfield(coeff[REG_X_ROW], 0) * pj + sfield(coeff[REG_X_ROW], 1) * pi
       + sfield(coeff[REG_X_ROW], 2) * (64'sd1 <<< 19);
    hy = sfield(coeff[REG_Y_ROW], 0) * pj + sfield(coeff[REG_Y_ROW], 1) * pi
       + sfield(coeff[REG_Y_ROW], 2) * (64'sd1 <<< 19);
    hz = sfield(coeff[REG_Z_ROW], 0) * pj + sfield(coeff[REG_Z_ROW], 1) * pi
       + sfield(coeff[REG_Z_ROW], 2) * (64'sd1 <<< 19);
    xn = norm_quotient(hx, hz, sat);
    yn = norm_quotient(hy, hz, sat);
    xx = round_shift(xn * xn, NFRAC);
    yy = round_shift(yn * yn, NFRAC);
    xy = round_shift(xn * yn, NFRAC);
    r2 = xx + yy;
    r4 = round_shift(r2 * r2, NFRAC);
    r6 = round_shift(r2 * r4, NFRAC);
    a1 = 2 * xy;
    a2 = r2 + 2 * xx;
    a3 = r2 + 2 * yy;
    cdist = (64'sd1 <<< NFRAC) + round_shift(k1 * r2, 17) + round_shift(k2 * r4, 17)
          + round_shift(k3 * r6, 17);
    cdist = clamp_sym(cdist, CDIST_LIM, sat);
    xd = round_shift(xn * cdist, NFRAC) + round_shift(p1 * a1, 17) + round_shift(p2 * a2, 17);
    yd = round_shift(yn * cdist, NFRAC) + round_shift(p1 * a3, 17) + round_shift(p2 * a1, 17);
    xd = clamp_sym(xd, DIST_LIM, sat);
    yd = clamp_sym(yd, DIST_LIM, sat);
    res.source_x = project_axis(xd, ufield(coeff[REG_FOCAL], 0),
                                ufield(coeff[REG_PRINCIPAL], 0), sat);
    res.source_y = project_axis(yd, ufield(coeff[REG_FOCAL], 1),
                                ufield(coeff[REG_PRINCIPAL], 1), sat);
    res.invalid = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_coords.size();

  always @(posedge clk) begin
    gpum_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) coeff[i] = '0;
      expected_coords.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        coeff[cfg_index] = cfg_data;
      if (in_valid && !in_stall)
        expected_coords.push_back(predict_source(in_data));
      if (out_valid && !out_stall) begin
        if (expected_coords.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_coords.pop_front();
          if (out_data.source_x !== want.source_x)
            report_mismatch("source_x", out_data.source_x, want.source_x);
          if (out_data.source_y !== want.source_y)
            report_mismatch("source_y", out_data.source_y, want.source_y);
          if (out_data.invalid !== want.invalid)
            report_mismatch("invalid", out_data.invalid, want.invalid);
        end
      end
    end
  end

  final begin
  end
endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the ground-plane remap block: coefficient settings from all
// zero through realistic cameras to saturating extremes, directed grid
// corners, then bursty random grid positions against a stalling sink.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpum_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;

  // coefficient settings exercised by the phases
  typedef enum int {
    SET_CAMERA, SET_ZERO_Z, SET_ONES, SET_MOST_NEG, SET_RANDOM, SET_SATURATE, SET_ZERO
  } setting_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gpum_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gpum_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit long_hold_req = 1'b0;
  int burst_left = 0;

  ground_plane_undistort_map dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gpum_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Sink: stall on segments of random density, with stretches of none; on
  // request hold off for a long stretch so the pipeline fills and stalls input.
  initial begin
    int seg_len;
    int density;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (300) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      seg_len = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0: density = 0;
        1: density = 20;
        2: density = 50;
        default: density = 90;
      endcase
      repeat (seg_len) begin
        out_stall <= ($urandom_range(0, 99) < density);
        @(posedge clk);
      end
    end
  end

  function automatic gpum_word_t pack_fields(int f2, int f1, int f0);
    return {f2[20:0], f1[20:0], f0[20:0]};
  endfunction

  function automatic int srand(int mag);
    return $urandom_range(0, 2 * mag) - mag;
  endfunction

  function automatic gpum_word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Write one register; entered and left on a rising edge, valid left high.
  task automatic write_reg(input int idx, input gpum_word_t value);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data  <= value;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Drain the pipeline, then load a full coefficient setting.
  task automatic load_setting(input setting_e mode);
    gpum_word_t w [NUM_REGS];
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    // camera looking down on the plane, used as a base by several settings
    w[REG_X_ROW]      = pack_fields(srand(20000), srand(30000), $urandom_range(150000, 480000));
    w[REG_Y_ROW]      = pack_fields(srand(20000), $urandom_range(150000, 480000), srand(30000));
    w[REG_Z_ROW]      = pack_fields($urandom_range(8000, 60000), srand(2000), srand(2000));
    w[REG_FOCAL]      = pack_fields(srand(1000), $urandom_range(60000, 300000),
                                    $urandom_range(60000, 300000));
    w[REG_PRINCIPAL]  = pack_fields(srand(1000), $urandom_range(0, 200000),
                                    $urandom_range(0, 200000));
    w[REG_RADIAL]     = pack_fields(srand(500), srand(3000), srand(13000));
    w[REG_TANGENTIAL] = pack_fields(srand(1000), srand(500), srand(500));
    w[REG_PLANE_OFS]  = pack_fields(srand(1000), srand(2000), srand(2000));
    case (mode)
      SET_ZERO_Z:   w[REG_Z_ROW] = '0;
      SET_ONES:     foreach (w[i]) w[i] = '1;
      SET_MOST_NEG: foreach (w[i]) w[i] = pack_fields(32'h100000, 32'h100000, 32'h100000);
      SET_RANDOM:   foreach (w[i]) w[i] = rand_word();
      SET_SATURATE: begin
        w[REG_Z_ROW]  = pack_fields($urandom_range(1, 40), srand(3), srand(3));
        w[REG_RADIAL] = pack_fields(32'h0FFFFF, 32'h0FFFFF, 32'h0FFFFF);
        w[REG_FOCAL]  = pack_fields(0, 32'h1FFFFF, 32'h1FFFFF);
      end
      SET_ZERO:     foreach (w[i]) w[i] = '0;
      default: ;
    endcase
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, w[i]);
    // indexes past the last register must be dropped
    write_reg(NUM_REGS + $urandom_range(0, 247), rand_word());
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one grid position, in bursts with random gaps in between.
  task automatic send_grid(input gpum_in_t g);
    bit stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= g;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  function automatic logic [IN_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int n);
    gpum_in_t g;
    repeat (n) begin
      g.grid_column = rand_coord();
      g.grid_row    = rand_coord();
      send_grid(g);
    end
  endtask

  task automatic send_corners();
    logic [IN_W-1:0] cols [8] = '{12'd0, 12'hFFF, 12'd0, 12'hFFF, 12'd1, 12'h800,
                                  12'hAAA, 12'h555};
    logic [IN_W-1:0] rows [8] = '{12'd0, 12'hFFF, 12'hFFF, 12'd0, 12'd1, 12'h800,
                                  12'h555, 12'hAAA};
    gpum_in_t g;
    foreach (cols[i]) begin
      g.grid_column = cols[i];
      g.grid_row    = rows[i];
      send_grid(g);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset coefficients give zero z with zero numerator
    send_corners();
    load_setting(SET_CAMERA);
    send_corners();
    load_setting(SET_ZERO_Z);
    send_corners();

    // random phases, one of them behind a long sink hold-off
    load_setting(SET_CAMERA);
    long_hold_req = 1'b1;
    send_random(200);
    load_setting(SET_SATURATE);
    send_random(100);
    load_setting(SET_ONES);
    send_random(60);
    load_setting(SET_MOST_NEG);
    send_random(60);
    load_setting(SET_RANDOM);
    send_random(100);
    load_setting(SET_ZERO_Z);
    send_random(60);
    load_setting(SET_CAMERA);
    send_random(160);
    load_setting(SET_ZERO);
    send_random(40);
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
